// ===== hdl/per_channel_circuit_breaker_defines.svh =====
// Assertion macros for the circuit breaker table.
`ifndef PER_CHANNEL_CIRCUIT_BREAKER_DEFINES_SVH
`define PER_CHANNEL_CIRCUIT_BREAKER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while reset is released.
`define PCB_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("%m: assertion failed");
// Checked at every edge, reset included.
`define PCB_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("%m: assertion failed");
`else
`define PCB_ASSERT(lbl, clk, rst_n, prop)
`define PCB_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hdl/pcb_pkg.sv =====
package pcb_pkg;

	localparam int unsigned CHANNELS_DEF = 64;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 1'd1;

	localparam logic [15:0] THRESHOLD_RST = 16'd5;
	localparam logic [15:0] TIMEOUT_RST   = 16'd30;

	// commands
	localparam logic [1:0] CMD_ALLOW   = 2'd0;
	localparam logic [1:0] CMD_SUCCESS = 2'd1;
	localparam logic [1:0] CMD_FAILURE = 2'd2;
	localparam logic [1:0] CMD_QUERY   = 2'd3;

	// breaker states
	localparam logic [1:0] ST_CLOSED = 2'd0;
	localparam logic [1:0] ST_OPEN   = 2'd1;
	localparam logic [1:0] ST_HALF   = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [5:0]  channel;
		logic [31:0] now_seconds;
	} in_item_t;

	typedef struct packed {
		logic       allowed;
		logic [1:0] breaker_state;
	} out_item_t;

	// one table entry; all zero is the reset value
	typedef struct packed {
		logic        known;
		logic [1:0]  st;
		logic [15:0] fail_count;
		logic [31:0] fail_time;
	} entry_t;

	typedef struct packed {
		logic     wr;
		entry_t   entry;
		out_item_t item;
	} upd_res_t;

endpackage

// ===== hdl/per_channel_circuit_breaker.sv =====
// Channel   | Dir | Handshake            | Payload
// in        | in  | in_valid / in_ready   | in_data   (command, channel, now_seconds)
// out       | out | out_valid / out_ready | out_data  (allowed, breaker_state)
// cfg       | in  | cfg_we (no wait)      | cfg_index, cfg_data
//
// Sustains one item per cycle while out is not stalled; the table is read into the
// stage-1 registers at the edge that takes the item, and the read-modify-write
// result goes into the output register when stage 1 advances.
// After arst_n is released a clearing pass writes every table entry, one per
// cycle; in_ready stays low until the pass ends.
// A stalled out holds one result; the stage behind it then holds and in_ready drops.
`include "per_channel_circuit_breaker_defines.svh"

module per_channel_circuit_breaker #(
	parameter int unsigned CHANNELS = pcb_pkg::CHANNELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  pcb_pkg::in_item_t                in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output pcb_pkg::out_item_t               out_data,
	input  logic                             cfg_we,
	input  logic [pcb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pcb_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import pcb_pkg::*;

	localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

	// config registers
	logic [15:0] thr_q;
	logic [15:0] tmo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RST;
			tmo_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: thr_q <= cfg_data;
				REG_TIMEOUT:   tmo_q <= cfg_data;
			endcase
		end
	end

	// clearing pass after reset
	logic             clr_q;
	logic [IDX_W-1:0] clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + IDX_W'(1);
			if (clr_idx_q == LAST_IDX)
				clr_q <= 1'b0;
		end
	end

	// handshake and stage control
	logic     valid_s1;
	logic     fwd_hit_s1;
	logic     s1_adv;
	logic     in_acc;
	logic     in_rng;
	in_item_t item_s1;
	logic     rng_s1;
	entry_t   rd_s1;
	entry_t   fwd_entry_s1;
	entry_t   entry_cur;
	upd_res_t upd;

	assign s1_adv   = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !clr_q && (!valid_s1 || s1_adv);
	assign in_acc   = in_valid && in_ready;
	assign in_rng   = 32'(in_data.channel) < CHANNELS;

	// table: one write port (clear or write-back), one registered read port
	entry_t           mem [CHANNELS];
	logic             mem_we;
	logic [IDX_W-1:0] waddr;
	logic [IDX_W-1:0] raddr;
	entry_t           wdata;

	assign mem_we = clr_q || (s1_adv && upd.wr);
	assign waddr  = clr_q ? clr_idx_q : IDX_W'(item_s1.channel);
	assign wdata  = clr_q ? entry_t'('0) : upd.entry;
	assign raddr  = IDX_W'(in_data.channel);

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= wdata;
		if (in_acc)
			rd_s1 <= mem[raddr];
	end

	// Same channel written back in the accept cycle: the read above sees the
	// old entry, so keep the fresh one and use it instead.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1   <= 1'b1;
				fwd_hit_s1 <= s1_adv && upd.wr && (item_s1.channel == in_data.channel);
			end else if (s1_adv) begin
				valid_s1   <= 1'b0;
				fwd_hit_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1      <= in_data;
			rng_s1       <= in_rng;
			fwd_entry_s1 <= upd.entry;
		end
	end

	assign entry_cur = fwd_hit_s1 ? fwd_entry_s1 : rd_s1;

	pcb_update u_update (
		.item     (item_s1),
		.in_range (rng_s1),
		.cur      (entry_cur),
		.thr      (thr_q),
		.tmo      (tmo_q),
		.res      (upd)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (s1_adv)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv)
			out_data <= upd.item;
	end

	// checks
	`PCB_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |=> (!out_valid && !valid_s1))
	`PCB_ASSERT(a_clr_once, clk, arst_n, !clr_q |=> !clr_q)
	`PCB_ASSERT(a_clr_empty, clk, arst_n, clr_q |-> (!valid_s1 && !out_valid))
	`PCB_ASSERT(a_fwd_live, clk, arst_n, fwd_hit_s1 |-> valid_s1)

endmodule

// ===== hdl/pcb_update.sv =====
module pcb_update (
	input  pcb_pkg::in_item_t item,
	input  logic              in_range,
	input  pcb_pkg::entry_t   cur,
	input  logic [15:0]       thr,
	input  logic [15:0]       tmo,
	output pcb_pkg::upd_res_t res
);
	import pcb_pkg::*;

	entry_t      nxt;
	logic        granted;
	logic [31:0] elapsed;
	logic [15:0] cnt_inc;

	assign elapsed = item.now_seconds - cur.fail_time;
	assign cnt_inc = (cur.fail_count == 16'hFFFF) ? cur.fail_count : cur.fail_count + 16'd1;

	always_comb begin
		nxt     = cur;
		granted = 1'b0;
		unique case (item.command)
			CMD_ALLOW: begin
				if (!cur.known) begin
					nxt.known      = 1'b1;
					nxt.st         = ST_CLOSED;
					nxt.fail_count = '0;
					granted        = 1'b1;
				end else if (cur.st == ST_OPEN) begin
					if (elapsed >= {16'd0, tmo}) begin
						nxt.st  = ST_HALF;
						granted = 1'b1;
					end
				end else begin
					granted = 1'b1;
				end
			end
			CMD_SUCCESS: begin
				if (cur.known && cur.st == ST_HALF) begin
					nxt.st         = ST_CLOSED;
					nxt.fail_count = '0;
				end
			end
			CMD_FAILURE: begin
				// counts even on an unknown entry
				nxt.fail_count = cnt_inc;
				nxt.fail_time  = item.now_seconds;
				if (cnt_inc >= thr) begin
					nxt.known = 1'b1;
					nxt.st    = ST_OPEN;
				end
			end
			CMD_QUERY: begin
			end
		endcase
	end

	always_comb begin
		res.wr                 = in_range;
		res.entry              = nxt;
		res.item.allowed       = in_range & granted;
		res.item.breaker_state = (in_range && nxt.known) ? nxt.st : ST_CLOSED;
	end

endmodule
